// ----- rtl/mrf_pkg.sv -----
// ----------------------------------------------------------------------------
// Modbus RTU request framer package
// Shared types, constants and the CRC-16/MODBUS byte update.
// ----------------------------------------------------------------------------
package mrf_pkg;

    localparam int FRAME_LEN = 8;
    localparam int CRC_LEN   = 2;
    localparam int CNT_W     = $clog2(FRAME_LEN + 1);

    localparam logic [7:0]  FN_READ_HOLDING = 8'h03;
    localparam logic [7:0]  FN_WRITE_SINGLE = 8'h06;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic        MODE_WRITE      = 1'b1;

    localparam int          ADDR_W         = 3;
    localparam logic        REG_SLAVE_ADDR = 1'b0;
    localparam logic [7:0]  SLAVE_RESET    = 8'h01;

    typedef struct packed {
        logic        mode;
        logic [15:0] reg_address;
        logic [15:0] qty_or_value;
    } req_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } beat_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic inject;
    } cell_ctrl_t;

    function automatic logic [15:0] crc_add_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ----- rtl/modbus_rtu_request_framer_core.sv -----
// ----------------------------------------------------------------------------
// Modbus RTU request framer
// Turns each request into an eight-byte RTU frame with CRC-16/MODBUS.
// ----------------------------------------------------------------------------
// Each request beat yields eight frame beats, one per cycle while the output
// is not stalled. The frame sits in a row of eight byte cells that shift
// towards the output; the CRC is folded in one byte per beat as the first six
// bytes leave, and its two bytes are injected into the head cells as the
// sixth byte goes. The next request is taken in the cycle the final byte of
// the previous frame is accepted.
module modbus_rtu_request_framer_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mrf_pkg::ADDR_W-1:0]       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  mrf_pkg::req_t                    req,
    output logic                             frame_valid,
    input  logic                             frame_stall,
    output mrf_pkg::beat_t                   frame
);

    logic [7:0]                slave_reg;
    logic [7:0]                slave_next;
    logic [mrf_pkg::CNT_W-1:0] cnt_reg;
    logic [mrf_pkg::CNT_W-1:0] cnt_next;
    logic                      load;
    logic                      shift;
    logic                      inject;
    logic                      reg_sel;
    logic [15:0]               crc_next;
    logic [7:0]                load_bytes [mrf_pkg::FRAME_LEN];
    logic [7:0]                cell_bytes [mrf_pkg::FRAME_LEN + 1];
    logic                      cell_lasts [mrf_pkg::FRAME_LEN + 1];

    assign pready  = 1'b1;
    assign reg_sel = (paddr[mrf_pkg::ADDR_W-1] == mrf_pkg::REG_SLAVE_ADDR);
    assign prdata  = reg_sel ? {24'h000000, slave_reg} : 32'h00000000;

    always_comb
    begin
        slave_next = slave_reg;
        if (psel && penable && pwrite && reg_sel)
            slave_next = pwdata[7:0];
    end

    assign frame_valid = (cnt_reg != '0);
    assign shift       = frame_valid && !frame_stall;
    assign req_stall   = !((cnt_reg == '0) ||
                           ((cnt_reg == mrf_pkg::CNT_W'(1)) && !frame_stall));
    assign load        = req_valid && !req_stall;
    assign inject      = (cnt_reg == mrf_pkg::CNT_W'(mrf_pkg::CRC_LEN + 1));

    always_comb
    begin
        cnt_next = cnt_reg;
        if (load)
            cnt_next = mrf_pkg::CNT_W'(mrf_pkg::FRAME_LEN);
        else if (shift)
            cnt_next = cnt_reg - mrf_pkg::CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_reg <= mrf_pkg::SLAVE_RESET;
            cnt_reg   <= '0;
        end
        else
        begin
            slave_reg <= slave_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < mrf_pkg::FRAME_LEN; i++)
            load_bytes[i] = 8'h00;
        load_bytes[0] = slave_reg;
        load_bytes[1] = (req.mode == mrf_pkg::MODE_WRITE) ? mrf_pkg::FN_WRITE_SINGLE
                                                           : mrf_pkg::FN_READ_HOLDING;
        load_bytes[2] = req.reg_address[15:8];
        load_bytes[3] = req.reg_address[7:0];
        load_bytes[4] = req.qty_or_value[15:8];
        load_bytes[5] = req.qty_or_value[7:0];
    end

    mrf_crc u_crc (
        .clk        (clk),
        .rst_n      (rst_n),
        .init       (load),
        .update     (shift && (cnt_reg > mrf_pkg::CNT_W'(mrf_pkg::CRC_LEN))),
        .data_byte  (cell_bytes[0]),
        .crc_next_q (crc_next)
    );

    assign cell_bytes[mrf_pkg::FRAME_LEN] = 8'h00;
    assign cell_lasts[mrf_pkg::FRAME_LEN] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < mrf_pkg::FRAME_LEN; g++)
        begin : g_cell
            mrf_pkg::cell_ctrl_t cctrl;
            logic [7:0]          inj;

            assign cctrl.load   = load;
            assign cctrl.shift  = shift;
            assign cctrl.inject = inject && (g < mrf_pkg::CRC_LEN);
            assign inj          = crc_next[(g % mrf_pkg::CRC_LEN) * 8 +: 8];

            mrf_cell u_cell (
                .clk         (clk),
                .ctrl        (cctrl),
                .load_byte   (load_bytes[g]),
                .load_last   (g == mrf_pkg::FRAME_LEN - 1),
                .inject_byte (inj),
                .shift_byte  (cell_bytes[g + 1]),
                .shift_last  (cell_lasts[g + 1]),
                .byte_q      (cell_bytes[g]),
                .last_q      (cell_lasts[g])
            );
        end
    endgenerate

    assign frame.frame_byte = cell_bytes[0];
    assign frame.last_byte  = cell_lasts[0];

endmodule

// ----- rtl/mrf_cell.sv -----
// ----------------------------------------------------------------------------
// Frame byte cell
// One byte of the outgoing frame; loads, shifts towards the head or takes
// an injected CRC byte.
// ----------------------------------------------------------------------------
module mrf_cell (
    input  logic                clk,
    input  mrf_pkg::cell_ctrl_t ctrl,
    input  logic [7:0]          load_byte,
    input  logic                load_last,
    input  logic [7:0]          inject_byte,
    input  logic [7:0]          shift_byte,
    input  logic                shift_last,
    output logic [7:0]          byte_q,
    output logic                last_q
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       last_reg;
    logic       last_next;

    always_comb
    begin
        byte_next = byte_reg;
        last_next = last_reg;
        if (ctrl.load)
        begin
            byte_next = load_byte;
            last_next = load_last;
        end
        else if (ctrl.shift)
        begin
            byte_next = ctrl.inject ? inject_byte : shift_byte;
            last_next = shift_last;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign byte_q = byte_reg;
    assign last_q = last_reg;

endmodule

// ----- rtl/mrf_crc.sv -----
// ----------------------------------------------------------------------------
// CRC-16/MODBUS accumulator
// Folds in one frame byte per beat as it leaves the head of the chain.
// ----------------------------------------------------------------------------
module mrf_crc (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        init,
    input  logic        update,
    input  logic [7:0]  data_byte,
    output logic [15:0] crc_next_q
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [15:0] crc_step;

    assign crc_step = mrf_pkg::crc_add_byte(crc_reg, data_byte);

    always_comb
    begin
        crc_next = crc_reg;
        if (init)
            crc_next = mrf_pkg::CRC_INIT;
        else if (update)
            crc_next = crc_step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_reg <= mrf_pkg::CRC_INIT;
        else
            crc_reg <= crc_next;
    end

    assign crc_next_q = crc_step;

endmodule
